// File: hdl/mac_learning_table_with_aging_defines.svh
// assertion macros for the mac learning table
`ifndef MAC_LEARNING_TABLE_WITH_AGING_DEFINES_SVH
`define MAC_LEARNING_TABLE_WITH_AGING_DEFINES_SVH

`ifndef SYNTHESIS
`define MLT_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mlt assertion failed");
`define MLT_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mlt assertion failed");
`else
`define MLT_ASSERT_IMP(lbl, ante, cons)
`define MLT_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

// File: hdl/mlt_pkg.sv
package mlt_pkg;

    localparam int TABLE_DEPTH_DEF = 64;

    localparam int OP_W   = 3;
    localparam int MAC_W  = 48;
    localparam int PORT_W = 4;
    localparam int AGE_W  = 16;
    localparam int ST_W   = 2;
    localparam int CNT_W  = 7;

    localparam logic [OP_W-1:0] OP_LEARN  = 3'd0;
    localparam logic [OP_W-1:0] OP_LOOKUP = 3'd1;
    localparam logic [OP_W-1:0] OP_ADD    = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK   = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_PRESENT   = 2'd1;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    localparam logic [AGE_W-1:0] AGE_LIMIT_RST = 16'd300;
    localparam logic [AGE_W-1:0] AGE_MAX       = 16'hFFFF;
    localparam logic [CNT_W-1:0] REMOVED_MAX   = 7'd127;

    typedef struct packed {
        logic [OP_W-1:0]   opcode;
        logic [MAC_W-1:0]  mac_address;
        logic [PORT_W-1:0] port_number;
        logic              static_entry;
    } req_t;

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic              found;
        logic [PORT_W-1:0] found_port;
        logic [CNT_W-1:0]  removed_count;
    } rsp_t;

    typedef struct packed {
        logic              valid;
        logic [MAC_W-1:0]  mac;
        logic [PORT_W-1:0] port;
        logic              is_static;
        logic [AGE_W-1:0]  age;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic load;
        logic clear;
        logic scan;
        logic finish;
    } cmd_t;

endpackage

// File: hdl/mlt_ifs.sv
interface mlt_req_if;
    import mlt_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface mlt_rsp_if;
    import mlt_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

// File: hdl/mlt_ram.sv
module mlt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// File: hdl/mlt_ctrl.sv
module mlt_ctrl #(
    parameter int TABLE_DEPTH = mlt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_ready,
    input  logic                           out_free,
    output mlt_pkg::cmd_t                  cmd,
    output logic [$clog2(TABLE_DEPTH)-1:0] addr
);
    import mlt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0]    state_reg;
    logic [2:0]    state_next;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] cnt_next;

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;
        req_ready  = 1'b0;
        unique case (state_reg)
            S_CLEAR:
            begin
                cmd.clear = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    cnt_next   = '0;
                    state_next = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (cnt_reg == LAST)
                begin
                    cnt_next   = '0;
                    state_next = S_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + AW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign addr = cnt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hdl/mlt_datapath.sv
module mlt_datapath #(
    parameter int TABLE_DEPTH = mlt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  mlt_pkg::cmd_t                  cmd,
    input  logic [$clog2(TABLE_DEPTH)-1:0] addr,
    input  mlt_pkg::req_t                  req_payload,
    input  logic                           cfg_we,
    input  logic [mlt_pkg::AGE_W-1:0]      cfg_wdata,
    input  logic                           rsp_ready,
    output logic                           rsp_valid,
    output mlt_pkg::rsp_t                  rsp_payload,
    output logic                           out_free
);
    import mlt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    logic [AGE_W-1:0] age_limit_reg;
    req_t             req_reg;
    logic             rd_pend_reg;
    logic [AW-1:0]    rd_addr_reg;
    logic             hit_reg;
    logic [AW-1:0]    hit_idx_reg;
    entry_t           hit_entry_reg;
    logic             free_reg;
    logic [AW-1:0]    free_idx_reg;
    logic [CNT_W-1:0] removed_reg;
    logic             rsp_valid_reg;
    rsp_t             rsp_reg;

    logic [ENTRY_W-1:0] rd_word;
    entry_t             rd_entry;
    logic               wr_en;
    logic [AW-1:0]      wr_addr;
    entry_t             wr_entry;

    logic             hit_now;
    logic             free_now;
    logic             tick_wb;
    logic [AGE_W-1:0] age_inc;
    logic             expire;
    entry_t           tick_entry;
    entry_t           new_entry;

    logic          fin_we;
    logic [AW-1:0] fin_addr;
    entry_t        fin_entry;
    rsp_t          fin_rsp;

    mlt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_DEPTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_entry),
        .rd_en   (cmd.scan),
        .rd_addr (addr),
        .rd_data (rd_word)
    );

    assign rd_entry = entry_t'(rd_word);

    // per-entry scan
    assign hit_now  = rd_pend_reg && rd_entry.valid
                      && (rd_entry.mac == req_reg.mac_address);
    assign free_now = rd_pend_reg && !rd_entry.valid && !free_reg;
    assign tick_wb  = rd_pend_reg && rd_entry.valid && (req_reg.opcode == OP_TICK);
    assign age_inc  = (rd_entry.age == AGE_MAX) ? rd_entry.age : rd_entry.age + 16'd1;
    assign expire   = age_inc >= age_limit_reg;

    always_comb
    begin
        tick_entry     = rd_entry;
        tick_entry.age = age_inc;
        if (expire)
        begin
            tick_entry.valid = 1'b0;
        end
    end

    always_comb
    begin
        new_entry           = '0;
        new_entry.valid     = 1'b1;
        new_entry.mac       = req_reg.mac_address;
        new_entry.port      = req_reg.port_number;
        new_entry.is_static = (req_reg.opcode == OP_ADD) && req_reg.static_entry;
    end

    // end of scan: table update and result
    always_comb
    begin
        fin_we    = 1'b0;
        fin_addr  = hit_idx_reg;
        fin_entry = hit_entry_reg;
        fin_rsp   = '0;
        unique case (req_reg.opcode)
            OP_LEARN:
            begin
                if (hit_reg)
                begin
                    fin_we         = !hit_entry_reg.is_static;
                    fin_entry.port = req_reg.port_number;
                end
                else if (free_reg)
                begin
                    fin_we    = 1'b1;
                    fin_addr  = free_idx_reg;
                    fin_entry = new_entry;
                end
                else
                begin
                    fin_rsp.status = ST_FULL;
                end
            end
            OP_LOOKUP:
            begin
                if (hit_reg)
                begin
                    fin_we             = 1'b1;
                    fin_entry.age      = '0;
                    fin_rsp.found      = 1'b1;
                    fin_rsp.found_port = hit_entry_reg.port;
                end
                else
                begin
                    fin_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_ADD:
            begin
                if (hit_reg)
                begin
                    fin_rsp.status = ST_PRESENT;
                end
                else if (free_reg)
                begin
                    fin_we    = 1'b1;
                    fin_addr  = free_idx_reg;
                    fin_entry = new_entry;
                end
                else
                begin
                    fin_rsp.status = ST_FULL;
                end
            end
            OP_DELETE:
            begin
                if (hit_reg)
                begin
                    fin_we          = 1'b1;
                    fin_entry.valid = 1'b0;
                end
                else
                begin
                    fin_rsp.status = ST_NOT_FOUND;
                end
            end
            OP_TICK:
            begin
                fin_rsp.removed_count = removed_reg;
            end
            default:
            begin
                fin_rsp = '0;
            end
        endcase
    end

    always_comb
    begin
        priority if (cmd.clear)
        begin
            wr_en    = 1'b1;
            wr_addr  = addr;
            wr_entry = '0;
        end
        else if (tick_wb)
        begin
            wr_en    = 1'b1;
            wr_addr  = rd_addr_reg;
            wr_entry = tick_entry;
        end
        else
        begin
            wr_en    = cmd.finish && fin_we;
            wr_addr  = fin_addr;
            wr_entry = fin_entry;
        end
    end

    assign out_free    = !rsp_valid_reg || rsp_ready;
    assign rsp_valid   = rsp_valid_reg;
    assign rsp_payload = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            age_limit_reg <= AGE_LIMIT_RST;
            rd_pend_reg   <= 1'b0;
            hit_reg       <= 1'b0;
            free_reg      <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                age_limit_reg <= cfg_wdata;
            end
            rd_pend_reg <= cmd.scan;
            if (cmd.load)
            begin
                hit_reg  <= 1'b0;
                free_reg <= 1'b0;
            end
            else
            begin
                if (hit_now)
                begin
                    hit_reg <= 1'b1;
                end
                if (free_now)
                begin
                    free_reg <= 1'b1;
                end
            end
            if (cmd.finish)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_addr_reg <= addr;
        if (cmd.load)
        begin
            req_reg     <= req_payload;
            removed_reg <= '0;
        end
        else if (tick_wb && expire && (removed_reg != REMOVED_MAX))
        begin
            removed_reg <= removed_reg + 7'd1;
        end
        if (hit_now)
        begin
            hit_idx_reg   <= rd_addr_reg;
            hit_entry_reg <= rd_entry;
        end
        if (free_now)
        begin
            free_idx_reg <= rd_addr_reg;
        end
        if (cmd.finish)
        begin
            rsp_reg <= fin_rsp;
        end
    end

endmodule

// File: hdl/mac_learning_table_with_aging.sv
// mac learning table with aging
// req: one transaction per operation (learn, lookup, add, delete, aging tick)
// rsp: exactly one result transaction per request, in request order
// cfg_we / cfg_wdata: writes age_limit, taken in any cycle, no read-back
// every operation scans all TABLE_DEPTH entries of the table ram, one per cycle
// through its single read port; after acceptance the scan, drain and finish
// states follow in turn, and the finish loads the result into the output
// register; the next request is accepted the cycle after the result is loaded,
// so no request is taken while an operation is still in progress
// a finished result waits in the output register, so a stalled receiver holds
// only the end of the following operation, never its acceptance
// after reset a clearing pass empties the table while req.ready stays low;
// age_limit resets to 300
`include "mac_learning_table_with_aging_defines.svh"

module mac_learning_table_with_aging #(
    parameter int TABLE_DEPTH = mlt_pkg::TABLE_DEPTH_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    mlt_req_if.sink                   req,
    mlt_rsp_if.source                 rsp,
    input  logic                      cfg_we,
    input  logic [mlt_pkg::AGE_W-1:0] cfg_wdata
);
    import mlt_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    cmd_t          cmd;
    logic [AW-1:0] addr;
    logic          out_free;
    logic          req_ready;
    logic          rsp_valid;
    rsp_t          rsp_payload;

    mlt_ctrl #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req.valid),
        .req_ready (req_ready),
        .out_free  (out_free),
        .cmd       (cmd),
        .addr      (addr)
    );

    mlt_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .addr        (addr),
        .req_payload (req.payload),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .rsp_ready   (rsp.ready),
        .rsp_valid   (rsp_valid),
        .rsp_payload (rsp_payload),
        .out_free    (out_free)
    );

    assign req.ready   = req_ready;
    assign rsp.valid   = rsp_valid;
    assign rsp.payload = rsp_payload;

    `MLT_ASSERT_NXT(a_busy_after_accept, req.valid && req.ready, !req.ready)
    `MLT_ASSERT_NXT(a_result_after_finish, cmd.finish, rsp.valid)
    `MLT_ASSERT_IMP(a_finish_not_overwrite, cmd.finish, !rsp.valid || rsp.ready)
    `MLT_ASSERT_IMP(a_found_ok, rsp.valid && rsp.payload.found, rsp.payload.status == ST_OK)

endmodule
